@@ hw/rtl/roel_pkg.sv @@
// Shared constants and control/status types for the ring-of-entries offset lookup.
package roel_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SIZE_BITS  = 16;

  localparam int SLOT_W   = $clog2(SLOT_COUNT);
  localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int HANDLE_W = 32;
  localparam int ESIZE_W  = 16;
  localparam int OFF_W    = 20;
  localparam int BOFF_W   = 16;
  localparam int HSLOT_W  = 4;

  localparam int HS_EXT_W = (SLOT_W > HSLOT_W) ? SLOT_W : HSLOT_W;
  localparam int SZ_EXT_W = (SIZE_BITS > ESIZE_W) ? SIZE_BITS : ESIZE_W;
  localparam int CMP_W    = (SIZE_BITS > OFF_W) ? SIZE_BITS : OFF_W;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_FIND = 1'b1;

  typedef struct packed {
    logic add_write;
    logic find_start;
    logic walk_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } sts_t;

endpackage

@@ hw/rtl/roel_ctrl.sv @@
// Sequencer for add, find walk and result hand-off.
module roel_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          action_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output roel_pkg::cmd_t cmd_o,
  input  roel_pkg::sts_t sts_i
);
  import roel_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (action_i == ACT_FIND) begin
            cmd_o.find_start = 1'b1;
            state_d          = S_WALK;
          end else begin
            cmd_o.add_write = 1'b1;
            state_d         = S_FIN;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_find_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && action_i == ACT_FIND) |=> state_q == S_WALK)
    else $error("find transfer did not start a walk");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result load did not raise out valid");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |-> !cmd_o.load_out)
    else $error("result loaded over a pending one");

endmodule

@@ hw/rtl/roel_dp.sv @@
// Ring storage, pointers, offset walk and result registers.
module roel_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  roel_pkg::cmd_t                   cmd_i,
  output roel_pkg::sts_t                   sts_o,
  input  logic [roel_pkg::HANDLE_W-1:0]    entry_handle_i,
  input  logic [roel_pkg::ESIZE_W-1:0]     entry_size_i,
  input  logic [roel_pkg::OFF_W-1:0]       char_offset_i,
  output logic                             found_o,
  output logic [roel_pkg::HANDLE_W-1:0]    hit_handle_o,
  output logic [roel_pkg::BOFF_W-1:0]      byte_offset_o,
  output logic [roel_pkg::HSLOT_W-1:0]     hit_slot_o
);
  import roel_pkg::*;

  logic [HANDLE_W-1:0]  handles_q [SLOT_COUNT];
  logic [SIZE_BITS-1:0] sizes_q   [SLOT_COUNT];

  logic [SLOT_W-1:0]    wr_q, rd_q, wr_nx, rd_nx;
  logic                 full_q;

  logic [SLOT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]     left_q, left_d, stored_cnt;
  logic [OFF_W-1:0]     rem_q, rem_d;
  logic [HANDLE_W-1:0]  rd_handle_q;
  logic [SIZE_BITS-1:0] rd_size_q;

  logic                 hit_q, hit_d;
  logic [HANDLE_W-1:0]  hhandle_q, hhandle_d;
  logic [BOFF_W-1:0]    hoff_q, hoff_d;
  logic [SLOT_W-1:0]    hslot_q, hslot_d;

  logic [SZ_EXT_W-1:0]  size_ext;
  logic [CMP_W-1:0]     rem_cmp, size_cmp, rem_sub;
  logic [HS_EXT_W-1:0]  hslot_ext;
  logic                 walk_done, in_entry;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOT_COUNT - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  assign size_ext = SZ_EXT_W'(entry_size_i);
  assign wr_nx    = next_slot(wr_q);
  assign rd_nx    = full_q ? next_slot(rd_q) : rd_q;

  always_comb begin
    if (full_q) begin
      stored_cnt = CNT_W'(SLOT_COUNT);
    end else if (wr_q >= rd_q) begin
      stored_cnt = CNT_W'(wr_q) - CNT_W'(rd_q);
    end else begin
      stored_cnt = CNT_W'(wr_q) + CNT_W'(SLOT_COUNT) - CNT_W'(rd_q);
    end
  end

  // Ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.add_write) begin
      wr_q   <= wr_nx;
      rd_q   <= rd_nx;
      full_q <= full_q || (wr_nx == rd_nx);
    end
  end

  // Entry storage; read data is registered at the next walk pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      handles_q[wr_q] <= entry_handle_i;
      sizes_q[wr_q]   <= size_ext[SIZE_BITS-1:0];
    end
    rd_handle_q <= handles_q[ptr_d];
    rd_size_q   <= sizes_q[ptr_d];
  end

  assign walk_done = hit_q || (left_q == '0);
  assign rem_cmp   = CMP_W'(rem_q);
  assign size_cmp  = CMP_W'(rd_size_q);
  assign in_entry  = rem_cmp < size_cmp;
  assign rem_sub   = rem_cmp - size_cmp;

  always_comb begin
    ptr_d     = ptr_q;
    left_d    = left_q;
    rem_d     = rem_q;
    hit_d     = hit_q;
    hhandle_d = hhandle_q;
    hoff_d    = hoff_q;
    hslot_d   = hslot_q;
    if (cmd_i.find_start || cmd_i.add_write) begin
      ptr_d     = rd_q;
      left_d    = cmd_i.find_start ? stored_cnt : '0;
      rem_d     = char_offset_i;
      hit_d     = 1'b0;
      hhandle_d = '0;
      hoff_d    = '0;
      hslot_d   = '0;
    end else if (cmd_i.walk_step && !walk_done) begin
      if (in_entry) begin
        hit_d     = 1'b1;
        hhandle_d = rd_handle_q;
        hoff_d    = rem_q[BOFF_W-1:0];
        hslot_d   = ptr_q;
      end else begin
        // zero-size entries fall through here
        rem_d  = rem_sub[OFF_W-1:0];
        ptr_d  = next_slot(ptr_q);
        left_d = left_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      left_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      left_q <= left_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    hhandle_q <= hhandle_d;
    hoff_q    <= hoff_d;
    hslot_q   <= hslot_d;
  end

  assign hslot_ext = HS_EXT_W'(hslot_q);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      found_o <= hit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hit_handle_o  <= hhandle_q;
      byte_offset_o <= hoff_q;
      hit_slot_o    <= hslot_ext[HSLOT_W-1:0];
    end
  end

  assign sts_o.walk_done = walk_done;

  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (wr_q == rd_q))
    else $error("full ring with unequal pointers");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= CNT_W'(SLOT_COUNT))
    else $error("walk count exceeds ring depth");

  a_hit_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q && cmd_i.walk_step) |=> (hit_q && $stable(hslot_q)))
    else $error("hit result changed during walk");

endmodule

@@ hw/rtl/ring_of_entries_offset_lookup.sv @@
// Top level: ring of entries with offset lookup, overwriting the oldest entry.
//
// An add goes from its input transfer to S_FIN, where its result is loaded into the output
// register once that register is free. A find walks the stored entries, oldest first, in
// S_WALK, up to the first hit or through all of them (at most SLOT_COUNT, 16 here); its
// result then waits in S_FIN likewise. The walk reads one ring slot per cycle through a
// single registered storage read port. One item is in flight at a time. A finished result
// sits in the output register, and in_ready rises in the same cycle that the result is
// loaded there. A result still held by the receiver stalls the next item only at its own
// hand-off, not at its input transfer. Every item, add or find, produces exactly one
// result; adds return all zeros.
module ring_of_entries_offset_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [roel_pkg::HANDLE_W-1:0] entry_handle_i,
  input  logic [roel_pkg::ESIZE_W-1:0]  entry_size_i,
  input  logic [roel_pkg::OFF_W-1:0]    char_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [roel_pkg::HANDLE_W-1:0] hit_handle_o,
  output logic [roel_pkg::BOFF_W-1:0]   byte_offset_o,
  output logic [roel_pkg::HSLOT_W-1:0]  hit_slot_o
);
  import roel_pkg::*;

  cmd_t cmd;
  sts_t sts;

  roel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  roel_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .entry_handle_i (entry_handle_i),
    .entry_size_i   (entry_size_i),
    .char_offset_i  (char_offset_i),
    .found_o        (found_o),
    .hit_handle_o   (hit_handle_o),
    .byte_offset_o  (byte_offset_o),
    .hit_slot_o     (hit_slot_o)
  );

endmodule

@@ test/tb_top.sv @@
// Testbench for the ring-of-entries offset lookup: directed and random adds/finds, scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import roel_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 1800;
  localparam logic [SZ_EXT_W-1:0] SIZE_MASK = {SZ_EXT_W{1'b1}} >> (SZ_EXT_W - SIZE_BITS);

  typedef struct packed {
    logic                action;
    logic [HANDLE_W-1:0] handle;
    logic [ESIZE_W-1:0]  size;
    logic [OFF_W-1:0]    offset;
  } item_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] handle;
    logic [BOFF_W-1:0]   boff;
    logic [HSLOT_W-1:0]  slot;
  } lookup_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                action_i;
  logic [HANDLE_W-1:0] entry_handle_i;
  logic [ESIZE_W-1:0]  entry_size_i;
  logic [OFF_W-1:0]    char_offset_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                found_o;
  logic [HANDLE_W-1:0] hit_handle_o;
  logic [BOFF_W-1:0]   byte_offset_o;
  logic [HSLOT_W-1:0]  hit_slot_o;

  ring_of_entries_offset_lookup dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .entry_handle_i,
    .entry_size_i,
    .char_offset_i,
    .out_valid_o,
    .out_ready_i,
    .found_o,
    .hit_handle_o,
    .byte_offset_o,
    .hit_slot_o
  );

  // Ring mirror
  logic [HANDLE_W-1:0] ring_handles [SLOT_COUNT];
  logic [SZ_EXT_W-1:0] ring_sizes   [SLOT_COUNT];
  int unsigned         wr_slot;
  int unsigned         rd_slot;
  logic                ring_full;

  lookup_t pending_lookups [$];
  int      error_count;
  bit      no_idle;
  bit      rx_hold_req;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned stored_entries();
    if (ring_full) return SLOT_COUNT;
    return (wr_slot + SLOT_COUNT - rd_slot) % SLOT_COUNT;
  endfunction

  function automatic int unsigned stored_bytes();
    int unsigned sum;
    sum = 0;
    for (int i = 0; i < stored_entries(); i++) sum += ring_sizes[(rd_slot + i) % SLOT_COUNT];
    return sum;
  endfunction

  function automatic lookup_t predict_lookup(item_t it);
    lookup_t        res;
    longint unsigned remain;
    int unsigned    count;
    int unsigned    s;
    res = '0;
    if (it.action == ACT_ADD) begin
      ring_handles[wr_slot] = it.handle;
      ring_sizes[wr_slot]   = SZ_EXT_W'(it.size) & SIZE_MASK;
      wr_slot = (wr_slot + 1) % SLOT_COUNT;
      if (ring_full) rd_slot = (rd_slot + 1) % SLOT_COUNT;
      if (wr_slot == rd_slot) ring_full = 1'b1;
    end else begin
      count  = stored_entries();
      remain = it.offset;
      s      = rd_slot;
      for (int i = 0; i < count; i++) begin
        if (remain < ring_sizes[s]) begin
          res.found  = 1'b1;
          res.handle = ring_handles[s];
          res.boff   = BOFF_W'(remain);
          res.slot   = HSLOT_W'(s);
          break;
        end
        remain -= ring_sizes[s];
        s = (s + 1) % SLOT_COUNT;
      end
    end
    return res;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int idle_gap();
    int unsigned pick;
    if (no_idle) return 0;
    pick = $urandom_range(99, 0);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(4, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic item_t add_item(logic [HANDLE_W-1:0] handle, logic [ESIZE_W-1:0] size);
    item_t it;
    it.action = ACT_ADD;
    it.handle = handle;
    it.size   = size;
    it.offset = OFF_W'($urandom());
    return it;
  endfunction

  function automatic item_t find_item(logic [OFF_W-1:0] offset);
    item_t it;
    it.action = ACT_FIND;
    it.handle = $urandom();
    it.size   = ESIZE_W'($urandom());
    it.offset = offset;
    return it;
  endfunction

  // Finds mostly land inside the stored data; the rest probe the end or are noise
  function automatic item_t random_item();
    int unsigned pick;
    int unsigned total;
    item_t       it;
    pick = $urandom_range(99, 0);
    if ($urandom_range(99, 0) < 45) begin
      if (pick < 10)      it = add_item($urandom(), '0);
      else if (pick < 75) it = add_item($urandom(), ESIZE_W'($urandom_range(40, 1)));
      else if (pick < 95) it = add_item($urandom(), ESIZE_W'($urandom()));
      else                it = add_item($urandom(), '1);
    end else begin
      total = stored_bytes();
      if (pick < 65 && total > 0) it = find_item(OFF_W'($urandom_range(total - 1, 0)));
      else if (pick < 80)         it = find_item(OFF_W'(total));
      else                        it = find_item(OFF_W'($urandom()));
    end
    return it;
  endfunction

  // Caller sits at a rising edge; returns at the edge of the transfer
  task automatic send_item(input item_t it);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= it.action;
    entry_handle_i <= it.handle;
    entry_size_i   <= it.size;
    char_offset_i  <= it.offset;
    do @(posedge clk_i); while (!in_ready_o);
    pending_lookups.push_back(predict_lookup(it));
  endtask

  task automatic test_empty_ring();
    send_item(find_item('0));
    send_item(find_item('1));
  endtask

  task automatic test_field_extremes();
    send_item(add_item('0, '0));
    send_item(add_item('1, '1));
    send_item(add_item(32'h5a5a_a5a5, 16'd1));
    send_item(find_item('0));                  // zero-size entry skipped
    send_item(find_item(OFF_W'(16'hfffe)));
    send_item(find_item(OFF_W'(17'h0ffff)));   // first byte of next entry
    send_item(find_item(OFF_W'(17'h10000)));   // just past stored data
    send_item(find_item('1));
  endtask

  task automatic test_wrap_overwrite();
    for (int i = 0; i < 15; i++) send_item(add_item(HANDLE_W'(32'h100 + i), 16'd1));
    send_item(find_item(OFF_W'(SLOT_COUNT - 1)));  // full ring: walk every slot
    send_item(find_item(OFF_W'(SLOT_COUNT)));
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_ITEMS; i++) send_item(random_item());
  endtask

  task automatic test_streaming();
    no_idle = 1'b1;
    for (int i = 0; i < 150; i++) send_item(random_item());
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_item(random_item());
  endtask

  initial begin : rx_side
    int stall;
    stall       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall       = RX_HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        stall = idle_gap();
        out_ready_i <= (stall == 0);
      end
    end
  end

  initial begin : result_check
    lookup_t exp;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_lookups.size() == 0) begin
          $error("result transfer with no expectation waiting");
          error_count++;
        end else begin
          exp = pending_lookups.pop_front();
          if (found_o !== exp.found) begin
            $error("found: expected %0d, got %0d", exp.found, found_o);
            error_count++;
          end
          if (hit_handle_o !== exp.handle) begin
            $error("hit_handle: expected %0h, got %0h", exp.handle, hit_handle_o);
            error_count++;
          end
          if (byte_offset_o !== exp.boff) begin
            $error("byte_offset: expected %0d, got %0d", exp.boff, byte_offset_o);
            error_count++;
          end
          if (hit_slot_o !== exp.slot) begin
            $error("hit_slot: expected %0d, got %0d", exp.slot, hit_slot_o);
            error_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main_seq
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ACT_ADD;
    entry_handle_i = '0;
    entry_size_i   = '0;
    char_offset_i  = '0;
    error_count    = 0;
    no_idle        = 1'b0;
    rx_hold_req    = 1'b0;
    wr_slot        = 0;
    rd_slot        = 0;
    ring_full      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_ring();
    test_field_extremes();
    test_wrap_overwrite();
    test_streaming();
    test_backpressure();
    test_random_mix();

    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_lookups.size() != 0) begin
      $error("%0d expected results never arrived", pending_lookups.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/roel_pkg.sv
hw/rtl/roel_ctrl.sv
hw/rtl/roel_dp.sv
hw/rtl/ring_of_entries_offset_lookup.sv
test/tb_top.sv
